FILE: src/rpec_pkg.sv
// Shared types, codes and constants of the read pair exon classifier.
package rpec_pkg;

   // Default sizing of the exon tables and coordinates
   localparam int RPEC_MAX_EXONS   = 64;
   localparam int RPEC_COORD_WIDTH = 32;

   // Fixed field widths
   localparam int COUNT_W = 7;
   localparam int SLOT_W  = 6;
   localparam int XCOORD_W = 32;
   localparam int NUM_W   = 8;
   localparam int TYPE_W  = 4;

   // Item kinds and table codes
   localparam logic ACT_LOAD     = 1'b0;
   localparam logic ACT_CLASSIFY = 1'b1;
   localparam logic TBL_A        = 1'b0;
   localparam logic TBL_B        = 1'b1;

   // Configuration register indexes
   localparam logic CSR_EXON_COUNT_A = 1'b0;
   localparam logic CSR_EXON_COUNT_B = 1'b1;

   // Pair types, dense in priority order
   typedef enum logic [TYPE_W-1:0] {
      PT_EE   = 4'd0,
      PT_EI   = 4'd1,
      PT_EJ   = 4'd2,
      PT_IE   = 4'd3,
      PT_II   = 4'd4,
      PT_IJ   = 4'd5,
      PT_JJ   = 4'd6,
      PT_JE   = 4'd7,
      PT_JI   = 4'd8,
      PT_NONE = 4'd9
   } pair_kind_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN_A,
      ST_SCAN_B,
      ST_FINISH
   } rpec_state_type;

   // Per-cycle control from the sequencer to the label units
   typedef struct packed {
      logic clear;
      logic hit_a;
      logic hit_b;
   } rpec_step_type;

   // First hits found for one read block
   typedef struct packed {
      logic             ex_found;
      logic [NUM_W-1:0] ex_num;
      logic             in_found;
      logic [NUM_W-1:0] in_num;
      logic             jn_found;
      logic [NUM_W-1:0] jn_num;
   } rpec_label_type;

endpackage

FILE: src/rpec_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module rpec_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/rpec_label.sv
// Label unit: tracks first exon, intron and junction hit of one read block.
module rpec_label #(
   parameter int MAX_EXONS   = rpec_pkg::RPEC_MAX_EXONS,
   parameter int COORD_WIDTH = rpec_pkg::RPEC_COORD_WIDTH,
   localparam int IW = $clog2(MAX_EXONS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear,
   input  logic                     hit,
   input  logic [IW-1:0]            idx,
   input  logic [COORD_WIDTH-1:0]   xs,
   input  logic [COORD_WIDTH-1:0]   xe,
   input  logic [COORD_WIDTH-1:0]   blk_s,
   input  logic [COORD_WIDTH-1:0]   blk_e,
   output rpec_pkg::rpec_label_type label
);
   import rpec_pkg::*;

   rpec_label_type           label_ff, label_in;
   logic [COORD_WIDTH-1:0]   prev_end_ff, prev_end_in;
   logic                     ex_hit, in_hit, js_hit, je_hit;

   // Compares of the block against the current and previous exon
   assign ex_hit = (blk_s >= xs) && (blk_e <= xe);
   assign in_hit = (idx != '0) && (blk_s > prev_end_ff) && (blk_e < xs);
   assign js_hit = (blk_s <= xs) && (blk_e >= xs);
   assign je_hit = (blk_s <= xe) && (blk_e >= xe);

   // Keep the first hit of each kind
   always_comb begin
      label_in    = label_ff;
      prev_end_in = prev_end_ff;
      if (clear) begin
         label_in = '0;
      end else if (hit) begin
         prev_end_in = xe;
         if (!label_ff.ex_found && ex_hit) begin
            label_in.ex_found = 1'b1;
            label_in.ex_num   = NUM_W'({1'b0, idx} + (IW+1)'(1));
         end
         if (!label_ff.in_found && in_hit) begin
            label_in.in_found = 1'b1;
            label_in.in_num   = NUM_W'(idx);
         end
         if (!label_ff.jn_found) begin
            priority if (js_hit) begin
               label_in.jn_found = 1'b1;
               label_in.jn_num   = NUM_W'({idx, 1'b1});
            end else if (je_hit) begin
               label_in.jn_found = 1'b1;
               label_in.jn_num   = NUM_W'({1'b0, idx, 1'b0} + (IW+2)'(2));
            end else begin
               // no boundary of this exon inside the block
               label_in.jn_found = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         label_ff <= '0;
      end else begin
         label_ff <= label_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_end_ff <= prev_end_in;
   end

   assign label = label_ff;

endmodule

FILE: src/rpec_seq.sv
// Sequencer: walks table A then table B through the RAM read port.
module rpec_seq #(
   parameter int MAX_EXONS = rpec_pkg::RPEC_MAX_EXONS,
   localparam int IW = $clog2(MAX_EXONS),
   localparam int CW = $clog2(MAX_EXONS + 1),
   localparam int AW = $clog2(2 * MAX_EXONS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    out_free,
   input  logic [CW-1:0]           count_a,
   input  logic [CW-1:0]           count_b,
   output logic                    idle,
   output logic                    rd_en,
   output logic [AW-1:0]           rd_addr,
   output logic [IW-1:0]           hit_idx,
   output logic                    load_rsp,
   output rpec_pkg::rpec_step_type step
);
   import rpec_pkg::*;

   rpec_state_type state_ff, state_in;
   logic [CW-1:0]  issue_ff, issue_in;
   logic           tag_valid_ff, tag_valid_in;
   logic [IW-1:0]  tag_idx_ff;
   logic           scan_done;
   logic           more_a, more_b;

   assign more_a    = issue_ff < count_a;
   assign more_b    = issue_ff < count_b;
   assign scan_done = ((state_ff == ST_SCAN_A) && !more_a && !tag_valid_ff) ||
                      ((state_ff == ST_SCAN_B) && !more_b && !tag_valid_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start) begin
            state_in = ST_SCAN_A;
         end
         ST_SCAN_A: if (scan_done) begin
            state_in = ST_SCAN_B;
         end
         ST_SCAN_B: if (scan_done) begin
            state_in = ST_FINISH;
         end
         ST_FINISH: if (out_free) begin
            state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      idle     = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = AW'(issue_ff[IW-1:0]);
      load_rsp = 1'b0;
      unique case (state_ff)
         ST_IDLE:   idle = 1'b1;
         ST_SCAN_A: rd_en = more_a;
         ST_SCAN_B: begin
            rd_en   = more_b;
            rd_addr = AW'(MAX_EXONS) + AW'(issue_ff[IW-1:0]);
         end
         ST_FINISH: load_rsp = out_free;
         default:   idle = 1'b0;
      endcase
   end

   // Read issue counter and the tag of the entry in flight
   always_comb begin
      priority if (scan_done) begin
         issue_in = '0;
      end else if (rd_en) begin
         issue_in = issue_ff + CW'(1);
      end else begin
         issue_in = issue_ff;
      end
      tag_valid_in = rd_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= '0;
         tag_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         tag_valid_ff <= tag_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_idx_ff <= issue_ff[IW-1:0];
   end

   assign hit_idx    = tag_idx_ff;
   assign step.clear = start;
   assign step.hit_a = tag_valid_ff && (state_ff == ST_SCAN_A);
   assign step.hit_b = tag_valid_ff && (state_ff == ST_SCAN_B);

`ifndef SYNTHESIS
   // A read is only in flight during a table walk
   assert property (@(posedge clock) disable iff (reset)
      tag_valid_ff |-> (state_ff == ST_SCAN_A) || (state_ff == ST_SCAN_B))
      else $error("rpec_seq: read data outside a table walk");
   // A walk never leaves a table before its last entry came back
   assert property (@(posedge clock) disable iff (reset)
      scan_done |-> !rd_en && !tag_valid_ff)
      else $error("rpec_seq: walk ended with a read pending");
   // Issue count stays within the table
   assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (issue_ff < CW'(MAX_EXONS)))
      else $error("rpec_seq: read beyond table");
`endif

endmodule

FILE: src/read_pair_exon_classifier.sv
// Top level of the read pair exon classifier: tables, sequencer, pair typing.
//
//  channel | direction | handshake          | moves
//  req_    | in        | req_valid/ready    | one item: exon load or read pair classify
//  rsp_    | out       | rsp_valid/ready    | one item per classify: type and two numbers
//  csr_    | in        | csr_we             | exon count of table A or B
//
// A load item is written to the tables at acceptance.
// A classify item holds the input until its walk is over and the result is loaded:
// each table walk does one RAM read per exon,
// A then B through the single read port, then the finish state loads the result.
// The next item is taken while the result waits; only a later finish waits for it.
// Reset clears the counts and control only; table contents stay until loaded.
module read_pair_exon_classifier #(
   parameter int MAX_EXONS   = rpec_pkg::RPEC_MAX_EXONS,
   parameter int COORD_WIDTH = rpec_pkg::RPEC_COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic                          req_table_sel,
   input  logic [rpec_pkg::SLOT_W-1:0]   req_exon_index,
   input  logic [rpec_pkg::XCOORD_W-1:0] req_exon_start,
   input  logic [rpec_pkg::XCOORD_W-1:0] req_exon_end,
   input  logic [rpec_pkg::XCOORD_W-1:0] req_read1_start,
   input  logic [rpec_pkg::XCOORD_W-1:0] req_read1_end,
   input  logic [rpec_pkg::XCOORD_W-1:0] req_read2_start,
   input  logic [rpec_pkg::XCOORD_W-1:0] req_read2_end,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rpec_pkg::TYPE_W-1:0]   rsp_pair_type,
   output logic [rpec_pkg::NUM_W-1:0]    rsp_first_number,
   output logic [rpec_pkg::NUM_W-1:0]    rsp_second_number,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [rpec_pkg::COUNT_W-1:0]  csr_wdata
);
   import rpec_pkg::*;

   localparam int IW = $clog2(MAX_EXONS);
   localparam int CW = $clog2(MAX_EXONS + 1);
   localparam int AW = $clog2(2 * MAX_EXONS);

   logic [COUNT_W-1:0]     count_a_ff, count_b_ff;
   logic [CW-1:0]          n_a, n_b;
   logic                   accept, start, load_we, idle;
   logic [AW-1:0]          waddr;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic [COORD_WIDTH-1:0] xs, xe;
   logic [IW-1:0]          hit_idx;
   logic                   load_rsp, out_free;
   rpec_step_type          step;
   rpec_label_type         lab_a, lab_b;
   logic [COORD_WIDTH-1:0] r1s_ff, r1e_ff, r2s_ff, r2e_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   pair_kind_type          type_ff, type_in;
   logic [NUM_W-1:0]       n1_ff, n1_in, n2_ff, n2_in;
   logic                   j1, j2;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff <= '0;
         count_b_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_EXON_COUNT_A: count_a_ff <= csr_wdata;
            CSR_EXON_COUNT_B: count_b_ff <= csr_wdata;
            default:          count_a_ff <= count_a_ff;
         endcase
      end
   end

   // Counts above the table size are clamped
   assign n_a = (32'(count_a_ff) > 32'(MAX_EXONS)) ? CW'(MAX_EXONS) : CW'(count_a_ff);
   assign n_b = (32'(count_b_ff) > 32'(MAX_EXONS)) ? CW'(MAX_EXONS) : CW'(count_b_ff);

   // Input handshake; loads write the tables directly
   assign req_ready = idle;
   assign accept    = req_valid && req_ready;
   assign start     = accept && (req_action == ACT_CLASSIFY);
   assign load_we   = accept && (req_action == ACT_LOAD) &&
                      (32'(req_exon_index) < 32'(MAX_EXONS));
   assign waddr     = (req_table_sel == TBL_B) ?
                      AW'(MAX_EXONS) + AW'(req_exon_index) : AW'(req_exon_index);

   // Read pair coordinates held for the walk
   always_ff @(posedge clock) begin
      if (start) begin
         r1s_ff <= COORD_WIDTH'(req_read1_start);
         r1e_ff <= COORD_WIDTH'(req_read1_end);
         r2s_ff <= COORD_WIDTH'(req_read2_start);
         r2e_ff <= COORD_WIDTH'(req_read2_end);
      end
   end

   rpec_ram #(.WIDTH(COORD_WIDTH), .DEPTH(2 * MAX_EXONS)) u_start_ram (
      .clock (clock),
      .we    (load_we),
      .waddr (waddr),
      .wdata (COORD_WIDTH'(req_exon_start)),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (xs)
   );

   rpec_ram #(.WIDTH(COORD_WIDTH), .DEPTH(2 * MAX_EXONS)) u_end_ram (
      .clock (clock),
      .we    (load_we),
      .waddr (waddr),
      .wdata (COORD_WIDTH'(req_exon_end)),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (xe)
   );

   rpec_seq #(.MAX_EXONS(MAX_EXONS)) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .count_a  (n_a),
      .count_b  (n_b),
      .idle     (idle),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .hit_idx  (hit_idx),
      .load_rsp (load_rsp),
      .step     (step)
   );

   rpec_label #(.MAX_EXONS(MAX_EXONS), .COORD_WIDTH(COORD_WIDTH)) u_label_a (
      .clock (clock),
      .reset (reset),
      .clear (step.clear),
      .hit   (step.hit_a),
      .idx   (hit_idx),
      .xs    (xs),
      .xe    (xe),
      .blk_s (r1s_ff),
      .blk_e (r1e_ff),
      .label (lab_a)
   );

   rpec_label #(.MAX_EXONS(MAX_EXONS), .COORD_WIDTH(COORD_WIDTH)) u_label_b (
      .clock (clock),
      .reset (reset),
      .clear (step.clear),
      .hit   (step.hit_b),
      .idx   (hit_idx),
      .xs    (xs),
      .xe    (xe),
      .blk_s (r2s_ff),
      .blk_e (r2e_ff),
      .label (lab_b)
   );

   // A junction counts only when neither an exon nor an intron matched
   assign j1 = lab_a.jn_found && !lab_a.ex_found && !lab_a.in_found;
   assign j2 = lab_b.jn_found && !lab_b.ex_found && !lab_b.in_found;

   // Pair type in priority order
   always_comb begin
      priority if (lab_a.ex_found && lab_b.ex_found) begin
         type_in = PT_EE; n1_in = lab_a.ex_num; n2_in = lab_b.ex_num;
      end else if (lab_a.ex_found && lab_b.in_found) begin
         type_in = PT_EI; n1_in = lab_a.ex_num; n2_in = lab_b.in_num;
      end else if (lab_a.ex_found && j2) begin
         type_in = PT_EJ; n1_in = lab_a.ex_num; n2_in = lab_b.jn_num;
      end else if (lab_a.in_found && lab_b.ex_found) begin
         type_in = PT_IE; n1_in = lab_a.in_num; n2_in = lab_b.ex_num;
      end else if (lab_a.in_found && lab_b.in_found) begin
         type_in = PT_II; n1_in = lab_a.in_num; n2_in = lab_b.in_num;
      end else if (lab_a.in_found && j2) begin
         type_in = PT_IJ; n1_in = lab_a.in_num; n2_in = lab_b.jn_num;
      end else if (j1 && j2) begin
         type_in = PT_JJ; n1_in = lab_a.jn_num; n2_in = lab_b.jn_num;
      end else if (j1 && lab_b.ex_found) begin
         type_in = PT_JE; n1_in = lab_a.jn_num; n2_in = lab_b.ex_num;
      end else if (j1 && lab_b.in_found) begin
         type_in = PT_JI; n1_in = lab_a.jn_num; n2_in = lab_b.in_num;
      end else begin
         type_in = PT_NONE; n1_in = '0; n2_in = '0;
      end
   end

   // Output register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      priority if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         type_ff <= type_in;
         n1_ff   <= n1_in;
         n2_ff   <= n2_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pair_type     = type_ff;
   assign rsp_first_number  = n1_ff;
   assign rsp_second_number = n2_ff;

`ifndef SYNTHESIS
   // A result is never written over one that was not taken
   assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> !rsp_valid_ff || rsp_ready)
      else $error("rpec: result overwritten");
   // Table writes only happen while no walk reads the RAM
   assert property (@(posedge clock) disable iff (reset)
      load_we |-> !rd_en)
      else $error("rpec: table write during walk");
   // A classify item blocks input until its walk is over
   assert property (@(posedge clock) disable iff (reset)
      start |=> !req_ready)
      else $error("rpec: input taken during walk");
   // A new result comes only from a finished walk
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(load_rsp))
      else $error("rpec: result without classify");
`endif

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the read pair exon classifier: random tables, read pairs, stalls.
module tb;
   import rpec_pkg::*;

   localparam int NX           = RPEC_MAX_EXONS;
   localparam int DRAIN_CYCLES = 2 * NX + 20;
   localparam int LONG_HOLD    = 600;
   localparam int N_PHASES     = 10;
   localparam int PRESSURE_PH  = 2;

   // One request item as offered on the req_ channel
   typedef struct {
      logic                action;
      logic                table_sel;
      logic [SLOT_W-1:0]   exon_index;
      logic [XCOORD_W-1:0] exon_start;
      logic [XCOORD_W-1:0] exon_end;
      logic [XCOORD_W-1:0] read1_start;
      logic [XCOORD_W-1:0] read1_end;
      logic [XCOORD_W-1:0] read2_start;
      logic [XCOORD_W-1:0] read2_end;
   } exon_item_type;

   // One classification result
   typedef struct {
      pair_kind_type    kind;
      logic [NUM_W-1:0] first_num;
      logic [NUM_W-1:0] second_num;
   } pair_result_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_action = 1'b0;
   logic                req_table_sel = 1'b0;
   logic [SLOT_W-1:0]   req_exon_index = '0;
   logic [XCOORD_W-1:0] req_exon_start = '0;
   logic [XCOORD_W-1:0] req_exon_end = '0;
   logic [XCOORD_W-1:0] req_read1_start = '0;
   logic [XCOORD_W-1:0] req_read1_end = '0;
   logic [XCOORD_W-1:0] req_read2_start = '0;
   logic [XCOORD_W-1:0] req_read2_end = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [TYPE_W-1:0]   rsp_pair_type;
   logic [NUM_W-1:0]    rsp_first_number;
   logic [NUM_W-1:0]    rsp_second_number;
   logic                csr_we = 1'b0;
   logic                csr_index = 1'b0;
   logic [COUNT_W-1:0]  csr_wdata = '0;

   // Item streams and bookkeeping
   exon_item_type   req_items[$];
   pair_result_type expected_pairs[$];
   logic            req_taken = 1'b0;
   int              items_queued = 0;
   int              items_accepted = 0;
   int              loads_accepted = 0;
   int              pairs_accepted = 0;
   int              results_checked = 0;
   int              err_count = 0;
   bit              kinds_reached [10];

   // Idle control
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;

   // Predictor copy of the tables and counts
   logic [XCOORD_W-1:0] pred_start [2][NX];
   logic [XCOORD_W-1:0] pred_end   [2][NX];
   logic [COUNT_W-1:0]  pred_count [2];

   // Stimulus-side view of the tables, updated as loads are queued
   logic [XCOORD_W-1:0] layout_start [2][NX];
   logic [XCOORD_W-1:0] layout_end   [2][NX];

   // Phase plan: counts, idle mode, scrambled tables, classify items
   int phase_cnt_a [N_PHASES] = '{1, 64, 3, 127, 0, 7, 16, 2, 9, 5};
   int phase_cnt_b [N_PHASES] = '{1, 64, 5, 100, 7, 0, 16, 2, 12, 33};
   int phase_mode  [N_PHASES] = '{0, 1, 2, 3, 0, 1, 2, 3, 0, 3};
   bit phase_scram [N_PHASES] = '{0, 0, 0, 0, 0, 0, 1, 0, 0, 0};
   int phase_pairs [N_PHASES] = '{50, 20, 50, 20, 50, 50, 50, 50, 50, 50};

   read_pair_exon_classifier u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_table_sel     (req_table_sel),
      .req_exon_index    (req_exon_index),
      .req_exon_start    (req_exon_start),
      .req_exon_end      (req_exon_end),
      .req_read1_start   (req_read1_start),
      .req_read1_end     (req_read1_end),
      .req_read2_start   (req_read2_start),
      .req_read2_end     (req_read2_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pair_type     (rsp_pair_type),
      .rsp_first_number  (rsp_first_number),
      .rsp_second_number (rsp_second_number),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // Clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Label one read block against one table: first exon, first intron, first junction
   function automatic void label_read(input logic tsel, input logic [XCOORD_W-1:0] s,
                                      input logic [XCOORD_W-1:0] e,
                                      output int ex_num, output int intr_num,
                                      output int jn_num);
      int n;
      n = (pred_count[tsel] > NX) ? NX : int'(pred_count[tsel]);
      ex_num = 0;
      intr_num = 0;
      jn_num = 0;
      for (int i = 0; i < n; i++)
         if (ex_num == 0 && s >= pred_start[tsel][i] && e <= pred_end[tsel][i])
            ex_num = i + 1;
      for (int i = 1; i < n; i++)
         if (intr_num == 0 && s > pred_end[tsel][i-1] && e < pred_start[tsel][i])
            intr_num = i;
      if (ex_num == 0 && intr_num == 0)
         for (int i = 0; i < n; i++)
            if (jn_num == 0) begin
               if (s <= pred_start[tsel][i] && e >= pred_start[tsel][i])
                  jn_num = 2 * i + 1;
               else if (s <= pred_end[tsel][i] && e >= pred_end[tsel][i])
                  jn_num = 2 * i + 2;
            end
   endfunction

   // Pair type from the two labels, in priority order
   function automatic pair_result_type classify_pair(input exon_item_type it);
      int e1, i1, j1, e2, i2, j2, n1, n2;
      pair_result_type r;
      label_read(TBL_A, it.read1_start, it.read1_end, e1, i1, j1);
      label_read(TBL_B, it.read2_start, it.read2_end, e2, i2, j2);
      n1 = 0;
      n2 = 0;
      if (e1 > 0 && e2 > 0) begin
         r.kind = PT_EE; n1 = e1; n2 = e2;
      end else if (e1 > 0 && i2 > 0) begin
         r.kind = PT_EI; n1 = e1; n2 = i2;
      end else if (e1 > 0 && j2 > 0) begin
         r.kind = PT_EJ; n1 = e1; n2 = j2;
      end else if (i1 > 0 && e2 > 0) begin
         r.kind = PT_IE; n1 = i1; n2 = e2;
      end else if (i1 > 0 && i2 > 0) begin
         r.kind = PT_II; n1 = i1; n2 = i2;
      end else if (i1 > 0 && j2 > 0) begin
         r.kind = PT_IJ; n1 = i1; n2 = j2;
      end else if (j1 > 0 && j2 > 0) begin
         r.kind = PT_JJ; n1 = j1; n2 = j2;
      end else if (j1 > 0 && e2 > 0) begin
         r.kind = PT_JE; n1 = j1; n2 = e2;
      end else if (j1 > 0 && i2 > 0) begin
         r.kind = PT_JI; n1 = j1; n2 = i2;
      end else begin
         r.kind = PT_NONE;
      end
      r.first_num = NUM_W'(n1);
      r.second_num = NUM_W'(n2);
      return r;
   endfunction

   task automatic flag_error(input string msg);
      err_count++;
      if (err_count <= 10)
         $display("ERROR: %s", msg);
   endtask

   // Driver: offer the next queued item, hold it until taken
   always @(negedge clock) begin : drive_req
      exon_item_type item;
      if (req_valid && !req_taken) begin
         // item still waiting for acceptance
      end else if (req_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
         item = req_items.pop_front();
         req_valid       <= 1'b1;
         req_action      <= item.action;
         req_table_sel   <= item.table_sel;
         req_exon_index  <= item.exon_index;
         req_exon_start  <= item.exon_start;
         req_exon_end    <= item.exon_end;
         req_read1_start <= item.read1_start;
         req_read1_end   <= item.read1_end;
         req_read2_start <= item.read2_start;
         req_read2_end   <= item.read2_end;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result side: random stalls, plus a long hold when one is requested
   always @(negedge clock) begin : drive_rsp_ready
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= LONG_HOLD;
         rsp_ready   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: check results against the oldest expectation, predict accepted items
   always @(posedge clock) begin : watch
      exon_item_type   it;
      pair_result_type want;
      req_taken <= req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (expected_pairs.size() == 0) begin
               flag_error($sformatf("unexpected result type %0d numbers %0d/%0d",
                                    rsp_pair_type, rsp_first_number, rsp_second_number));
            end else begin
               want = expected_pairs.pop_front();
               if (rsp_pair_type !== want.kind || rsp_first_number !== want.first_num ||
                   rsp_second_number !== want.second_num)
                  flag_error($sformatf({"result %0d: expected type %0d numbers %0d/%0d, ",
                                        "got type %0d numbers %0d/%0d"},
                                       results_checked, want.kind, want.first_num,
                                       want.second_num, rsp_pair_type, rsp_first_number,
                                       rsp_second_number));
            end
         end
         if (req_valid && req_ready) begin
            items_accepted++;
            it.action      = req_action;
            it.table_sel   = req_table_sel;
            it.exon_index  = req_exon_index;
            it.exon_start  = req_exon_start;
            it.exon_end    = req_exon_end;
            it.read1_start = req_read1_start;
            it.read1_end   = req_read1_end;
            it.read2_start = req_read2_start;
            it.read2_end   = req_read2_end;
            if (it.action == ACT_LOAD) begin
               loads_accepted++;
               pred_start[it.table_sel][it.exon_index] = it.exon_start;
               pred_end[it.table_sel][it.exon_index]   = it.exon_end;
            end else begin
               pairs_accepted++;
               want = classify_pair(it);
               kinds_reached[int'(want.kind)] = 1'b1;
               expected_pairs.push_back(want);
            end
         end
      end
   end

   // Stimulus helpers
   function automatic exon_item_type random_fill();
      exon_item_type it;
      it.action      = 1'($urandom);
      it.table_sel   = 1'($urandom);
      it.exon_index  = SLOT_W'($urandom);
      it.exon_start  = $urandom;
      it.exon_end    = $urandom;
      it.read1_start = $urandom;
      it.read1_end   = $urandom;
      it.read2_start = $urandom;
      it.read2_end   = $urandom;
      return it;
   endfunction

   task automatic push_item(input exon_item_type it);
      if (it.action == ACT_LOAD) begin
         layout_start[it.table_sel][it.exon_index] = it.exon_start;
         layout_end[it.table_sel][it.exon_index]   = it.exon_end;
      end
      req_items.push_back(it);
      items_queued++;
   endtask

   task automatic push_load(input logic tsel, input int slot, input logic [XCOORD_W-1:0] xs,
                            input logic [XCOORD_W-1:0] xe);
      exon_item_type it;
      it = random_fill();
      it.action     = ACT_LOAD;
      it.table_sel  = tsel;
      it.exon_index = SLOT_W'(slot);
      it.exon_start = xs;
      it.exon_end   = xe;
      push_item(it);
   endtask

   task automatic push_pair(input logic [XCOORD_W-1:0] s1, input logic [XCOORD_W-1:0] e1,
                            input logic [XCOORD_W-1:0] s2, input logic [XCOORD_W-1:0] e2);
      exon_item_type it;
      it = random_fill();
      it.action      = ACT_CLASSIFY;
      it.read1_start = s1;
      it.read1_end   = e1;
      it.read2_start = s2;
      it.read2_end   = e2;
      push_item(it);
   endtask

   // Write a count register; only called while the block is idle
   task automatic write_count(input logic idx, input int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= COUNT_W'(value);
      pred_count[idx] = COUNT_W'(value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait until every item is taken and every result is back, then let the block drain
   task automatic settle();
      while (items_accepted != items_queued || expected_pairs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_idle_mode(input int mode);
      case (mode)
         1: begin
            send_idle_pct = 55; recv_stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0; recv_stall_pct = 55;
         end
         3: begin
            send_idle_pct = 24; recv_stall_pct = 24;
         end
         default: begin
            send_idle_pct = 0; recv_stall_pct = 0;
         end
      endcase
   endtask

   // Fill slots 0..n-1 with ordered exons, or with arbitrary ones when scrambled
   task automatic build_table(input logic tsel, input int n, input bit scramble);
      logic [XCOORD_W-1:0] pos, xs, xe;
      case ($urandom_range(2))
         0:       pos = $urandom_range(1000);
         1:       pos = $urandom_range(32'hFFF0_0000);
         default: pos = 32'hFFFF_E000 + $urandom_range(1000);
      endcase
      for (int i = 0; i < n; i++) begin
         if (scramble) begin
            xs = $urandom;
            xe = $urandom_range(1) ? xs + $urandom_range(500) : $urandom;
         end else begin
            xs  = pos + $urandom_range(60, 2);
            xe  = xs + $urandom_range(40);
            pos = xe;
         end
         push_load(tsel, i, xs, xe);
      end
   endtask

   // Choose a read block that lands in an exon, an intron, across a boundary or elsewhere
   function automatic void pick_block(input logic tsel, input int n,
                                      output logic [XCOORD_W-1:0] s,
                                      output logic [XCOORD_W-1:0] e);
      int k, j;
      logic [XCOORD_W-1:0] xs, xe, lo, hi;
      s = $urandom;
      e = $urandom;
      if (n == 0)
         return;
      k  = $urandom_range(n - 1);
      xs = layout_start[tsel][k];
      xe = layout_end[tsel][k];
      case ($urandom_range(9))
         0, 1: begin
            s = xs + $urandom_range(xe - xs);
            e = s + $urandom_range(xe - s);
         end
         2, 3: begin
            if (k > 0) begin
               lo = layout_end[tsel][k-1] + 1;
               hi = xs - 1;
               s  = lo + $urandom_range(hi - lo);
               e  = s + $urandom_range(hi - s);
            end
         end
         4: begin
            s = xs - $urandom_range(20);
            e = xs + $urandom_range(20);
         end
         5: begin
            s = xe - $urandom_range(20);
            e = xe + $urandom_range(20);
         end
         6: begin
            j = $urandom_range(k);
            s = layout_start[tsel][j] - $urandom_range(5);
            e = xe + $urandom_range(5);
         end
         7: begin
            if ($urandom_range(1)) begin
               e = layout_start[tsel][0] - 1 - $urandom_range(50);
               s = e - $urandom_range(50);
            end else begin
               s = layout_end[tsel][n-1] + 1 + $urandom_range(50);
               e = s + $urandom_range(50);
            end
         end
         8: begin
            // fully random block
         end
         default: begin
            // reversed block starting inside an exon
            s = xs + $urandom_range(xe - xs);
            e = s - $urandom_range(30, 1);
         end
      endcase
   endfunction

   // Main sequence
   initial begin : run
      int na, nb, slot, kinds;
      logic tsel;
      logic [XCOORD_W-1:0] s1, e1, s2, e2;
      for (int t = 0; t < 2; t++)
         for (int i = 0; i < NX; i++) begin
            layout_start[t][i] = '0;
            layout_end[t][i]   = '0;
         end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty tables first
      set_idle_mode(0);
      write_count(CSR_EXON_COUNT_A, 0);
      write_count(CSR_EXON_COUNT_B, 0);
      push_pair(32'd150, 32'd160, 32'd1050, 32'd1060);
      push_pair(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      settle();

      // Directed: three exons per table, every pair type
      write_count(CSR_EXON_COUNT_A, 3);
      write_count(CSR_EXON_COUNT_B, 3);
      push_load(TBL_A, 0, 32'd100, 32'd200);
      push_load(TBL_A, 1, 32'd300, 32'd400);
      push_load(TBL_A, 2, 32'd500, 32'd600);
      push_load(TBL_B, 0, 32'd1000, 32'd1100);
      push_load(TBL_B, 1, 32'd1200, 32'd1300);
      push_load(TBL_B, 2, 32'd1400, 32'd1500);
      push_load(TBL_A, NX - 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_load(TBL_B, NX - 1, 32'h0, 32'hFFFF_FFFF);
      push_pair(32'd150, 32'd160, 32'd1050, 32'd1060);   // exon / exon
      push_pair(32'd150, 32'd160, 32'd1150, 32'd1160);   // exon / intron
      push_pair(32'd150, 32'd160, 32'd1090, 32'd1110);   // exon / junction
      push_pair(32'd250, 32'd260, 32'd1050, 32'd1060);   // intron / exon
      push_pair(32'd250, 32'd260, 32'd1250, 32'd1260);   // intron / intron
      push_pair(32'd250, 32'd260, 32'd950, 32'd1000);    // intron / junction
      push_pair(32'd190, 32'd310, 32'd1290, 32'd1410);   // junction / junction
      push_pair(32'd50, 32'd150, 32'd1450, 32'd1460);    // junction / exon
      push_pair(32'd590, 32'd610, 32'd1350, 32'd1360);   // junction / intron
      push_pair(32'd150, 32'd160, 32'd2000, 32'd3000);   // no rule applies
      push_pair(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
      push_pair(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_pair(32'h0, 32'h0, 32'h0, 32'h0);
      push_pair(32'd400, 32'd300, 32'd1300, 32'd1200);   // reversed blocks
      push_pair(32'd200, 32'd200, 32'd1400, 32'd1400);   // single-base on a boundary
      settle();

      // Random phases
      for (int p = 0; p < N_PHASES; p++) begin
         set_idle_mode(phase_mode[p]);
         write_count(CSR_EXON_COUNT_A, phase_cnt_a[p]);
         write_count(CSR_EXON_COUNT_B, phase_cnt_b[p]);
         na = (phase_cnt_a[p] > NX) ? NX : phase_cnt_a[p];
         nb = (phase_cnt_b[p] > NX) ? NX : phase_cnt_b[p];
         build_table(TBL_A, na, phase_scram[p]);
         build_table(TBL_B, nb, phase_scram[p]);
         if (p == PRESSURE_PH)
            hold_requests++;
         for (int k = 0; k < phase_pairs[p]; k++) begin
            if ($urandom_range(99) < 8) begin
               // occasional reload: mostly the same entry again, sometimes noise
               tsel = 1'($urandom_range(1));
               slot = $urandom_range(NX - 1);
               if ($urandom_range(3) != 0)
                  push_load(tsel, slot, layout_start[tsel][slot], layout_end[tsel][slot]);
               else
                  push_load(tsel, slot, $urandom, $urandom);
            end
            pick_block(TBL_A, na, s1, e1);
            pick_block(TBL_B, nb, s2, e2);
            push_pair(s1, e1, s2, e2);
         end
         settle();
      end

      if (expected_pairs.size() != 0)
         flag_error($sformatf("%0d results never arrived", expected_pairs.size()));

      kinds = 0;
      for (int i = 0; i < 10; i++)
         kinds += kinds_reached[i];
      $display("Covered %0d items (%0d exon loads, %0d read pairs) over %0d table settings.",
               items_accepted, loads_accepted, pairs_accepted, N_PHASES + 2);
      $display("Checked %0d results, %0d of 10 pair types reached, %0d errors.",
               results_checked, kinds, err_count);
      if (err_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #10ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
